// File: rtl/mks_pkg.sv
// Shared types, constants and the key character table of the keypad scanner.
package mks_pkg;

   localparam int unsigned COL_WIDTH      = 4;
   localparam int unsigned ROW_WIDTH      = 4;
   localparam int unsigned KEY_WIDTH      = 7;
   localparam int unsigned PAGE_WIDTH     = 2;
   localparam int unsigned COUNT_WIDTH    = 16;
   localparam int unsigned BASE_WIDTH     = 4;
   localparam int unsigned SCAN_WIDTH     = 2;
   localparam int unsigned PHASE_WIDTH    = 3;
   localparam int unsigned DEF_NUM_PAGES  = 3;
   localparam int unsigned ROWS_PER_PAGE  = 4;

   localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [COL_WIDTH-1:0]   COLS_IDLE      = 4'hF;
   localparam logic [COL_WIDTH-1:0]   COL_ONE_LOW    = 4'hE;
   localparam logic [COL_WIDTH-1:0]   COL_TWO_LOW    = 4'hD;
   localparam logic [COL_WIDTH-1:0]   COL_THREE_LOW  = 4'hB;
   localparam logic [COL_WIDTH-1:0]   COL_FOUR_LOW   = 4'h7;
   localparam logic [KEY_WIDTH-1:0]   HASH_KEY       = 7'h23;

   localparam logic [PHASE_WIDTH-1:0] PH_RELEASE  = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_PRESS    = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_DEBOUNCE = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_SCAN     = 3'd3;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]  row_drive;
      logic                  key_valid;
      logic [KEY_WIDTH-1:0]  key_code;
      logic [PAGE_WIDTH-1:0] page_now;
   } result_type;

   // Character at one table row and column; the fourth page repeats the first.
   function automatic logic [KEY_WIDTH-1:0] key_lookup(input logic [BASE_WIDTH-1:0] row,
                                                       input logic [1:0] col);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (row[1:0])
         2'd0: begin
            unique case ({row[3:2], col})
               4'h0: ch = "0"; 4'h1: ch = "1"; 4'h2: ch = "2"; 4'h3: ch = "3";
               4'h4: ch = "a"; 4'h5: ch = "b"; 4'h6: ch = "c"; 4'h7: ch = "d";
               4'h8: ch = "o"; 4'h9: ch = "p"; 4'hA: ch = "q"; 4'hB: ch = "r";
               default: begin
                  unique case (col)
                     2'd0: ch = "0"; 2'd1: ch = "1"; 2'd2: ch = "2"; default: ch = "3";
                  endcase
               end
            endcase
         end
         2'd1: begin
            unique case ({row[3:2], col})
               4'h0: ch = "4"; 4'h1: ch = "5"; 4'h2: ch = "6"; 4'h3: ch = "7";
               4'h4: ch = "e"; 4'h5: ch = "f"; 4'h6: ch = "g"; 4'h7: ch = "h";
               4'h8: ch = "s"; 4'h9: ch = "t"; 4'hA: ch = "u"; 4'hB: ch = "v";
               default: begin
                  unique case (col)
                     2'd0: ch = "4"; 2'd1: ch = "5"; 2'd2: ch = "6"; default: ch = "7";
                  endcase
               end
            endcase
         end
         2'd2: begin
            unique case ({row[3:2], col})
               4'h0: ch = "8"; 4'h1: ch = "9"; 4'h2: ch = "="; 4'h3: ch = "~";
               4'h4: ch = "i"; 4'h5: ch = "j"; 4'h6: ch = "="; 4'h7: ch = "k";
               4'h8: ch = "w"; 4'h9: ch = "x"; 4'hA: ch = "="; 4'hB: ch = "y";
               default: begin
                  unique case (col)
                     2'd0: ch = "8"; 2'd1: ch = "9"; 2'd2: ch = "="; default: ch = "~";
                  endcase
               end
            endcase
         end
         default: begin
            unique case ({row[3:2], col})
               4'h0: ch = "%"; 4'h1: ch = "&"; 4'h2: ch = "@"; 4'h3: ch = "#";
               4'h4: ch = "l"; 4'h5: ch = "m"; 4'h6: ch = "n"; 4'h7: ch = "#";
               4'h8: ch = "z"; 4'h9: ch = ";"; 4'hA: ch = ":"; 4'hB: ch = "#";
               default: begin
                  unique case (col)
                     2'd0: ch = "%"; 2'd1: ch = "&"; 2'd2: ch = "@"; default: ch = "#";
                  endcase
               end
            endcase
         end
      endcase
      return ch[KEY_WIDTH-1:0];
   endfunction

endpackage

// File: rtl/mks_core.sv
// Scan state machine: one column sample per enabled cycle, producing one result word.
module mks_core #(
   parameter int unsigned NUM_PAGES = mks_pkg::DEF_NUM_PAGES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cfg_write,
   input  logic [mks_pkg::COUNT_WIDTH-1:0]      cfg_data,
   input  logic                                 step_enable,
   input  logic [mks_pkg::COL_WIDTH-1:0]        col_sense,
   output mks_pkg::result_type                  result
);
   import mks_pkg::*;

   localparam int unsigned PAGE_LIMIT = ROWS_PER_PAGE * NUM_PAGES;
   localparam int unsigned SUM_WIDTH  = BASE_WIDTH + 1;
   localparam logic [SUM_WIDTH-1:0] PAGE_LIMIT_V = SUM_WIDTH'(PAGE_LIMIT);
   localparam logic [SUM_WIDTH-1:0] PAGE_STEP_V  = SUM_WIDTH'(ROWS_PER_PAGE);

   logic [COUNT_WIDTH-1:0] debounce_ff, debounce_in;
   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [SCAN_WIDTH-1:0]  scan_row_ff, scan_row_in;
   logic [COUNT_WIDTH-1:0] wait_count_ff, wait_count_in;
   logic [BASE_WIDTH-1:0]  page_base_ff, page_base_in;
   logic [KEY_WIDTH-1:0]   last_key_ff, last_key_in;

   logic [COUNT_WIDTH-1:0] limit;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   cols_idle;
   logic                   col_hit;
   logic [1:0]             col_index;
   logic [BASE_WIDTH-1:0]  table_row;
   logic [SUM_WIDTH-1:0]   page_sum;
   logic                   key_valid;

   assign limit      = (debounce_ff == '0) ? COUNT_WIDTH'(1) : debounce_ff;
   assign count_next = wait_count_ff + COUNT_WIDTH'(1);
   assign cols_idle  = (col_sense == COLS_IDLE);
   assign table_row  = page_base_ff + BASE_WIDTH'(scan_row_ff);

   always_comb begin
      col_hit   = 1'b1;
      col_index = 2'd0;
      unique case (col_sense)
         COL_ONE_LOW:   col_index = 2'd0;
         COL_TWO_LOW:   col_index = 2'd1;
         COL_THREE_LOW: col_index = 2'd2;
         COL_FOUR_LOW:  col_index = 2'd3;
         default:       col_hit   = 1'b0;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      scan_row_in   = scan_row_ff;
      wait_count_in = wait_count_ff;
      page_base_in  = page_base_ff;
      last_key_in   = last_key_ff;
      key_valid     = 1'b0;
      page_sum      = '0;
      unique case (phase_ff)
         PH_PRESS: begin
            if (!cols_idle) begin
               phase_in      = PH_DEBOUNCE;
               wait_count_in = '0;
            end
         end
         PH_DEBOUNCE: begin
            wait_count_in = count_next;
            // A wrapped count also ends the wait.
            if (count_next >= limit || count_next == '0) begin
               wait_count_in = '0;
               if (!cols_idle) begin
                  phase_in    = PH_SCAN;
                  scan_row_in = '0;
               end else begin
                  phase_in = PH_PRESS;
               end
            end
         end
         PH_SCAN: begin
            if (!cols_idle) begin
               if (col_hit) begin
                  last_key_in = key_lookup(table_row, col_index);
                  key_valid   = 1'b1;
               end
               // The test uses the kept key too, so a retained hash pages again.
               if (last_key_in == HASH_KEY) begin
                  page_sum = SUM_WIDTH'(page_base_ff) + PAGE_STEP_V;
                  page_base_in = (page_sum >= PAGE_LIMIT_V) ? '0
                                                            : page_sum[BASE_WIDTH-1:0];
               end
               phase_in = PH_RELEASE;
            end else begin
               scan_row_in = scan_row_ff + SCAN_WIDTH'(1);
            end
         end
         default: begin
            phase_in = cols_idle ? PH_PRESS : PH_RELEASE;
         end
      endcase
   end

   assign debounce_in = cfg_write ? cfg_data : debounce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         phase_ff      <= PH_RELEASE;
         scan_row_ff   <= '0;
         wait_count_ff <= '0;
         page_base_ff  <= '0;
         last_key_ff   <= '0;
      end else begin
         debounce_ff <= debounce_in;
         if (step_enable) begin
            phase_ff      <= phase_in;
            scan_row_ff   <= scan_row_in;
            wait_count_ff <= wait_count_in;
            page_base_ff  <= page_base_in;
            last_key_ff   <= last_key_in;
         end
      end
   end

   always_comb begin
      result.row_drive = '0;
      if (phase_in == PH_SCAN) begin
         result.row_drive = ~(ROW_WIDTH'(1) << scan_row_in);
      end
      result.key_valid = key_valid;
      result.key_code  = last_key_in;
      result.page_now  = page_base_in[BASE_WIDTH-1:2];
   end

endmodule

// File: rtl/mks_out_queue.sv
// Two-word result queue: an output register with a skid entry behind it.
module mks_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mks_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output mks_pkg::result_type out_data
);
   import mks_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !out_stall;
   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      priority if (push && pop) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// File: rtl/matrix_keypad_scanner_top.sv
// Top level of the debounced 4x4 matrix keypad scanner.
// Each accepted request word carries one column sample and yields exactly one response
// word with the row drive, key flag, key code and page index. The sample is registered
// in the input register, the scan state machine then decides on it combinationally, and
// the response word enters a two-entry output queue, so one word per cycle flows through
// while the response side does not stall. The debounce register is written through the
// csr port, which is always ready; write it only while no words are in flight.
module matrix_keypad_scanner_top #(
   parameter int unsigned NUM_PAGES = mks_pkg::DEF_NUM_PAGES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mks_pkg::COL_WIDTH-1:0]     req_col_sense,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mks_pkg::ROW_WIDTH-1:0]     rsp_row_drive,
   output logic                              rsp_key_valid,
   output logic [mks_pkg::KEY_WIDTH-1:0]     rsp_key_code,
   output logic [mks_pkg::PAGE_WIDTH-1:0]    rsp_page_now,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mks_pkg::COUNT_WIDTH-1:0]   csr_debounce_ticks
);
   import mks_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [COL_WIDTH-1:0] in_cols_ff, in_cols_in;
   logic                 accept;
   logic                 advance;
   logic                 queue_full;
   result_type           step_result;
   result_type           rsp_data;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && !queue_full;
   assign req_stall = in_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign in_cols_in  = accept ? req_col_sense : in_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_cols_ff <= in_cols_in;
   end

   mks_core #(
      .NUM_PAGES (NUM_PAGES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg_write   (csr_valid && csr_ready),
      .cfg_data    (csr_debounce_ticks),
      .step_enable (advance),
      .col_sense   (in_cols_ff),
      .result      (step_result)
   );

   mks_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (step_result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_row_drive = rsp_data.row_drive;
   assign rsp_key_valid = rsp_data.key_valid;
   assign rsp_key_code  = rsp_data.key_code;
   assign rsp_page_now  = rsp_data.page_now;

endmodule
